FILE: hw/rtl/conv2d_5x5_bias_relu_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 5x5 convolution block.
// Every module that uses them has clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CONV2D_5X5_BIAS_RELU_DEFINES_SVH
`define CONV2D_5X5_BIAS_RELU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CV5_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CV5_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition must hold on every cycle out of reset.
`define CV5_ASSERT_ALWAYS(name, cond, msg) \
	`CV5_ASSERT_IMP(name, 1'b1, cond, msg)

`endif

FILE: hw/rtl/cv5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv5_pkg
// Shared constants and types of the 5x5 convolution block.
// ----------------------------------------------------------------------------
package cv5_pkg;

	localparam int DEF_IMAGE_ROWS = 32;
	localparam int DEF_IMAGE_COLS = 32;

	localparam int KERNEL_SIZE = 5;
	localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int FEAT_W      = 15;
	localparam int WIDX_W      = 5;
	localparam int BIAS_W      = 32;
	// Wide enough for any column of the largest supported image.
	localparam int COL_IDX_W   = 10;

	// Accumulator growth: 5 products per row, 25 products plus bias in total.
	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int ROW_W  = PROD_W + 2;
	localparam int HALF_W = PROD_W + 3;
	localparam int ACC_W  = PROD_W + 4;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	typedef enum logic {
		OP_PIXEL  = 1'b0,
		OP_WEIGHT = 1'b1
	} op_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		op_t                    op;
		logic [SAMPLE_BITS-1:0] data;
		logic [WIDX_W-1:0]      widx;
		logic [COL_IDX_W-1:0]   col;
		logic                   produce;
		logic                   last;
	} cmd_t;

	typedef struct packed {
		logic              last;
		logic [FEAT_W-1:0] feat;
	} res_t;

endpackage

FILE: hw/rtl/cv5_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv5_front
// Accepts input words, tracks the raster position and tags each sample.
// ----------------------------------------------------------------------------
`include "conv2d_5x5_bias_relu_defines.svh"

module cv5_front
	import cv5_pkg::*;
#(
	parameter int IMAGE_ROWS = DEF_IMAGE_ROWS,
	parameter int IMAGE_COLS = DEF_IMAGE_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic                          operation,
	input  logic signed [SAMPLE_BITS-1:0] pixel_value,
	input  logic [WIDX_W-1:0]             weight_index,
	input  logic signed [SAMPLE_BITS-1:0] weight_value,
	output logic                          cmd_push,
	output cmd_t                          cmd
);

	localparam int ROW_W = $clog2(IMAGE_ROWS);
	localparam int COL_W = $clog2(IMAGE_COLS);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             accept;
	logic             is_weight;
	logic             idx_ok;
	logic             row_last;
	logic             col_last;

	assign accept    = push && !full;
	assign is_weight = (op_t'(operation) == OP_WEIGHT);
	assign idx_ok    = (weight_index < WIDX_W'(TAPS));
	assign row_last  = (row_q == ROW_W'(IMAGE_ROWS - 1));
	assign col_last  = (col_q == COL_W'(IMAGE_COLS - 1));

	// Weight loads to a position outside the kernel are dropped here.
	assign cmd_push = accept && (!is_weight || idx_ok);

	always_comb begin
		cmd.op      = op_t'(operation);
		cmd.data    = is_weight ? weight_value : pixel_value;
		cmd.widx    = weight_index;
		cmd.col     = COL_IDX_W'(col_q);
		cmd.produce = !is_weight && (row_q >= ROW_W'(KERNEL_SIZE - 1))
			&& (col_q >= COL_W'(KERNEL_SIZE - 1));
		cmd.last    = !is_weight && row_last && col_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept && !is_weight) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	`CV5_ASSERT_ALWAYS(a_pos_range, (row_q <= ROW_W'(IMAGE_ROWS - 1)) && (col_q <= COL_W'(IMAGE_COLS - 1)), "raster position out of range")
	`CV5_ASSERT_NXT(a_col_wrap, accept && !is_weight && col_last, col_q == '0, "column did not wrap")
	`CV5_ASSERT_IMP(a_last_produces, cmd_push && cmd.last, cmd.produce, "frame end without window")

endmodule

FILE: hw/rtl/cv5_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv5_fifo
// Small register FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module cv5_fifo
	import cv5_pkg::*;
#(
	parameter int WIDTH = $bits(cmd_t),
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cv5_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv5_back
// Line buffers, 5x5 window, kernel store and the multiply-accumulate pipe.
// ----------------------------------------------------------------------------
`include "conv2d_5x5_bias_relu_defines.svh"

module cv5_back
	import cv5_pkg::*;
#(
	parameter int IMAGE_COLS = DEF_IMAGE_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [BIAS_W-1:0] cfg_data,
	input  logic              cmd_empty,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic              res_take,
	output logic              res_push,
	output res_t              res
);

	localparam int COL_W     = $clog2(IMAGE_COLS);
	localparam int LB_W      = (KERNEL_SIZE - 1) * SAMPLE_BITS;
	localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
	localparam int HALF_ROWS = (KERNEL_SIZE + 1) / 2;

	logic signed [BIAS_W-1:0] bias_q;
	logic [CREDIT_W-1:0]      credit_q;
	logic                     produce_pop;

	// One memory word per column holds the previous four rows, newest in the low slice.
	logic [LB_W-1:0] lb_mem_q [IMAGE_COLS];
	logic [LB_W-1:0] lb_rd_s1;
	logic            v_s1;
	cmd_t            cmd_s1;
	logic            pix_s1;
	sample_t         new_col [KERNEL_SIZE];
	sample_t         win_q [KERNEL_SIZE][KERNEL_SIZE];

	logic            v_s2;
	cmd_t            cmd_s2;
	sample_t         kern_q [TAPS];

	logic signed [PROD_W-1:0] prod_s3 [TAPS];
	logic                     res_s3;
	logic                     last_s3;

	logic signed [ROW_W-1:0]  row_sum [KERNEL_SIZE];
	logic signed [ROW_W-1:0]  row_s4 [KERNEL_SIZE];
	logic                     res_s4;
	logic                     last_s4;

	logic signed [HALF_W-1:0] half_a;
	logic signed [HALF_W-1:0] half_b;
	logic signed [HALF_W-1:0] half_a_s5;
	logic signed [HALF_W-1:0] half_b_s5;
	logic                     res_s5;
	logic                     last_s5;

	logic signed [ACC_W-1:0]  acc_s6;
	logic                     res_s6;
	logic                     last_s6;

	// A sample that makes a result waits in the queue until the result queue has room
	// for everything already in flight.
	assign cmd_pop     = !cmd_empty && (!cmd.produce || (credit_q < CREDIT_W'(OUT_DEPTH)));
	assign produce_pop = cmd_pop && cmd.produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q   <= '0;
			credit_q <= '0;
		end else begin
			if (cfg_write) begin
				bias_q <= cfg_data;
			end
			case ({produce_pop, res_take})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Stage 1: line buffer read, then write back with the rows shifted by one.
	assign pix_s1 = v_s1 && (cmd_s1.op == OP_PIXEL);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
			if (cmd.op == OP_PIXEL) begin
				lb_rd_s1 <= lb_mem_q[cmd.col[COL_W-1:0]];
			end
		end
		if (pix_s1) begin
			lb_mem_q[cmd_s1.col[COL_W-1:0]] <=
				{lb_rd_s1[LB_W-SAMPLE_BITS-1:0], cmd_s1.data};
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE - 1; r++) begin
			new_col[r] = lb_rd_s1[(KERNEL_SIZE - 2 - r) * SAMPLE_BITS +: SAMPLE_BITS];
		end
		new_col[KERNEL_SIZE-1] = cmd_s1.data;
	end

	// Window row 0 is the oldest image row, column 0 the leftmost sample.
	always_ff @(posedge clk) begin
		if (pix_s1) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][KERNEL_SIZE-1] <= new_col[r];
			end
		end
	end

	// Stage 2: products use the kernel as it stands, and a weight word updates the
	// kernel on the same edge, so weights and samples keep their arrival order.
	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		if (v_s2 && (cmd_s2.op == OP_WEIGHT)) begin
			kern_q[cmd_s2.widx] <= cmd_s2.data;
		end
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				prod_s3[r*KERNEL_SIZE+c] <= PROD_W'(win_q[r][c])
					* PROD_W'(kern_q[r*KERNEL_SIZE+c]);
			end
		end
		last_s3 <= cmd_s2.last;
	end

	// Stage 3 and 4: row sums, then two half sums with the bias folded in.
	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			row_sum[r] = '0;
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				row_sum[r] = row_sum[r] + ROW_W'(prod_s3[r*KERNEL_SIZE+c]);
			end
		end
	end

	always_comb begin
		half_a = '0;
		half_b = HALF_W'(bias_q);
		for (int r = 0; r < HALF_ROWS; r++) begin
			half_a = half_a + HALF_W'(row_s4[r]);
		end
		for (int r = HALF_ROWS; r < KERNEL_SIZE; r++) begin
			half_b = half_b + HALF_W'(row_s4[r]);
		end
	end

	always_ff @(posedge clk) begin
		row_s4    <= row_sum;
		last_s4   <= last_s3;
		half_a_s5 <= half_a;
		half_b_s5 <= half_b;
		last_s5   <= last_s4;
		acc_s6    <= ACC_W'(half_a_s5) + ACC_W'(half_b_s5);
		last_s6   <= last_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			res_s3 <= 1'b0;
			res_s4 <= 1'b0;
			res_s5 <= 1'b0;
			res_s6 <= 1'b0;
		end else begin
			v_s1   <= cmd_pop;
			v_s2   <= v_s1;
			res_s3 <= v_s2 && cmd_s2.produce;
			res_s4 <= res_s3;
			res_s5 <= res_s4;
			res_s6 <= res_s5;
		end
	end

	// ReLU, drop the fraction bits of the product scale, saturate.
	always_comb begin
		res.last = last_s6;
		if (acc_s6[ACC_W-1] || (acc_s6 == '0)) begin
			res.feat = '0;
		end else if (|acc_s6[ACC_W-2:FRAC_BITS+FEAT_W]) begin
			res.feat = '1;
		end else begin
			res.feat = acc_s6[FRAC_BITS +: FEAT_W];
		end
	end

	assign res_push = res_s6;

	`CV5_ASSERT_ALWAYS(a_credit_bound, credit_q <= CREDIT_W'(OUT_DEPTH), "credit count overflow")
	`CV5_ASSERT_IMP(a_take_has_credit, res_take, credit_q != '0, "result taken without credit")
	`CV5_ASSERT_ALWAYS(a_inflight_covered, ($countones({res_s3, res_s4, res_s5, res_s6}) <= int'(credit_q)), "results in flight exceed credit")
	`CV5_ASSERT_IMP(a_weight_silent, v_s1 && (cmd_s1.op == OP_WEIGHT), !cmd_s1.produce, "weight word marked as producing")

endmodule

FILE: hw/rtl/conv2d_5x5_bias_relu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_5x5_bias_relu
// Streaming 5x5 valid convolution with bias and ReLU on one image channel.
// ----------------------------------------------------------------------------
//  channel   handshake            fields
//  input     push / full          operation, pixel_value, weight_index, weight_value
//  result    pop / empty          feature_value, frame_last
//  config    cfg_write            cfg_data (bias)
//
//  One word is accepted per cycle while full is low; a result passes the command queue,
//  the six-stage line buffer, multiply and adder-tree pipeline and the result queue.
//  Reset clears the position counters, the queues and the bias; no clearing pass.
//  The command queue holds 4 words; full rises only when the back end stalls.
//  The back end holds samples that make results once 8 results are outstanding.
// ----------------------------------------------------------------------------
module conv2d_5x5_bias_relu
	import cv5_pkg::*;
#(
	parameter int IMAGE_ROWS = DEF_IMAGE_ROWS,
	parameter int IMAGE_COLS = DEF_IMAGE_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          operation,
	input  logic signed [SAMPLE_BITS-1:0] pixel_value,
	input  logic [WIDX_W-1:0]             weight_index,
	input  logic signed [SAMPLE_BITS-1:0] weight_value,
	output logic                          empty,
	input  logic                          pop,
	output logic [FEAT_W-1:0]             feature_value,
	output logic                          frame_last,
	input  logic                          cfg_write,
	input  logic [BIAS_W-1:0]             cfg_data
);

	cmd_t                   cmd_in;
	logic                   cmd_push;
	logic [$bits(cmd_t)-1:0] cmd_head_raw;
	cmd_t                   cmd_head;
	logic                   cmd_empty;
	logic                   cmd_pop;
	res_t                   res_in;
	logic                   res_push;
	logic [$bits(res_t)-1:0] res_head_raw;
	res_t                   res_head;
	logic                   res_take;

	cv5_front #(
		.IMAGE_ROWS(IMAGE_ROWS),
		.IMAGE_COLS(IMAGE_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.pixel_value (pixel_value),
		.weight_index(weight_index),
		.weight_value(weight_value),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	cv5_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_head_raw),
		.empty (cmd_empty)
	);

	assign cmd_head = cmd_t'(cmd_head_raw);

	cv5_back #(
		.IMAGE_COLS(IMAGE_COLS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_head),
		.cmd_pop  (cmd_pop),
		.res_take (res_take),
		.res_push (res_push),
		.res      (res_in)
	);

	cv5_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (),
		.pop   (pop),
		.rdata (res_head_raw),
		.empty (empty)
	);

	assign res_head      = res_t'(res_head_raw);
	assign res_take      = pop && !empty;
	assign feature_value = res_head.feat;
	assign frame_last    = res_head.last;

endmodule
